[rtl/ttps_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ttps_pkg: shared types for the transposition table probe/store block
// Operation and bound codes, key width and the layout of one table slot.
// ----------------------------------------------------------------------------
package ttps_pkg;

  localparam int KEY_W   = 64;
  localparam int SCORE_W = 32;
  localparam int DEPTH_W = 16;
  localparam int GEN_W   = 32;

  typedef enum logic [1:0] {
    OP_PROBE  = 2'd0,
    OP_STORE  = 2'd1,
    OP_NEWGEN = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BOUND_EXACT = 2'd0,
    BOUND_LOWER = 2'd1,
    BOUND_UPPER = 2'd2
  } bound_t;

  // One slot without its move word; the move lives in a memory of its own.
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0] depth;
    logic [1:0]         bound;
    logic [GEN_W-1:0]   age;
    logic               has_move;
  } entry_t;

endpackage
`default_nettype wire

[rtl/ttps_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ttps_ram: simple dual-port synchronous RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ttps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/ttps_index.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ttps_index: slot index from a 64-bit key
// Power-of-two tables take the low key bits in the request cycle. Other sizes
// fold in the key one byte at a time, each byte a reciprocal multiply followed
// by a subtract and one correction.
// ----------------------------------------------------------------------------
module ttps_index #(
  parameter int ENTRIES = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ttps_pkg::KEY_W-1:0] key,
  output logic                            done,
  output logic [$clog2(ENTRIES)-1:0]      idx
);

  localparam int IDX_W = $clog2(ENTRIES);

  if ((ENTRIES & (ENTRIES - 1)) == 0) begin : g_pow2

    assign idx  = key[IDX_W-1:0];
    assign done = start;

  end else begin : g_mod

    localparam int DIGIT = 8;
    localparam int STEPS = 2 * (ttps_pkg::KEY_W / DIGIT);
    localparam int CNT_W = $clog2(STEPS);
    localparam int Y_W   = IDX_W + DIGIT;
    localparam int SHR   = Y_W + IDX_W;
    localparam int RCP_W = Y_W + 1;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << SHR) / 64'(ENTRIES));
    localparam logic [Y_W-1:0] ENT = Y_W'(ENTRIES);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic [ttps_pkg::KEY_W-1:0] shift;
    logic [IDX_W-1:0]           rem;
    logic [IDX_W-1:0]           rem_next;
    logic [Y_W-1:0]             y;
    logic [Y_W-1:0]             y_held;
    logic [2*Y_W:0]             prod;
    logic [DIGIT-1:0]           quot;
    logic [Y_W-1:0]             diff;
    logic [CNT_W-1:0]           cnt;
    logic                       run;

    // The quotient estimate is low by at most one, so one subtract corrects it.
    assign y    = {rem, shift[ttps_pkg::KEY_W-1 -: DIGIT]};
    assign prod = {{(Y_W + 1){1'b0}}, y} * {{Y_W{1'b0}}, RECIP};

    always_comb begin
      diff = y_held - {{(Y_W - DIGIT){1'b0}}, quot} * ENT;
      if (diff >= ENT) begin
        diff = diff - ENT;
      end
      rem_next = diff[IDX_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        run <= 1'b0;
        cnt <= '0;
      end else if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          run <= 1'b0;
        end
      end
    end

    // Even steps estimate the quotient, odd steps reduce the remainder.
    always_ff @(posedge clk) begin
      if (start) begin
        shift <= key;
        rem   <= '0;
      end else if (run) begin
        if (!cnt[0]) begin
          y_held <= y;
          quot   <= prod[SHR +: DIGIT];
          shift  <= shift << DIGIT;
        end else begin
          rem <= rem_next;
        end
      end
    end

    assign done = run && (cnt == LAST);
    assign idx  = rem_next;

  end

endmodule
`default_nettype wire

[rtl/transposition_table_probe_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// transposition_table_probe_store: direct-mapped search result table
// Probe, store (depth-preferred replacement), new generation and clear.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request gives
// exactly one result, shown for one cycle with done high; the receiver cannot
// stall it, so it must take the result in that cycle. Probe and store are one
// read-modify-write of the slot: with ENTRIES a power of two a request goes
// through a slot read, then compare and write back; otherwise the serial
// remainder that forms the slot index runs first. New generation without a
// wrap leaves busy low. Clear, and a new generation that wraps the age, sweep
// the slot memory one entry a cycle, so busy stays high until the last entry
// is cleared; done rises together with busy. After reset the same sweep runs,
// with busy high until it ends.
// ----------------------------------------------------------------------------
module transposition_table_probe_store #(
  parameter int ENTRIES   = 1024,
  parameter int MOVE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation,
  input  wire logic [63:0] key,
  input  wire logic [15:0] depth,
  input  wire logic signed [31:0] score,
  input  wire logic [1:0]  bound,
  input  wire logic signed [31:0] alpha,
  input  wire logic signed [31:0] beta,
  input  wire logic        has_move,
  input  wire logic [31:0] move,
  output logic             done,
  output logic             hit,
  output logic             cutoff,
  output logic signed [31:0] cutoff_score,
  output logic signed [31:0] new_alpha,
  output logic signed [31:0] new_beta,
  output logic [15:0]      entry_depth,
  output logic [1:0]       entry_bound,
  output logic             move_valid,
  output logic [31:0]      move_out,
  output logic             written
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int ENT_W = $bits(ttps_pkg::entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_INDEX  = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_CLEAR  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [IDX_W-1:0] sweep;
  logic [31:0]      generation;

  // Latched request
  ttps_pkg::op_t    req_op;
  logic [63:0]      req_key;
  logic [15:0]      req_depth;
  logic [31:0]      req_score;
  logic [1:0]       req_bound;
  logic signed [31:0] req_alpha;
  logic signed [31:0] req_beta;
  logic             req_has_move;
  logic [31:0]      req_move;
  logic [IDX_W-1:0] req_idx;

  logic             accept;
  logic             idx_start;
  logic             idx_done;
  logic [IDX_W-1:0] idx;

  ttps_pkg::entry_t ent_rd;
  logic [ENT_W-1:0] ent_rdata;
  ttps_pkg::entry_t ent_wr;
  logic             ent_we;
  logic [IDX_W-1:0] ent_waddr;
  logic [MOVE_BITS-1:0] mv_rdata;
  logic [MOVE_BITS-1:0] mv_wdata;
  logic             mv_we;
  logic [31:0]      mv_rd32;

  // Lookup-stage results
  logic             lk_hit;
  logic             lk_deep;
  logic             lk_cut;
  logic             lk_repl;
  logic signed [31:0] lk_score;
  logic signed [31:0] lk_alpha;
  logic signed [31:0] lk_beta;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign idx_start = accept && (ttps_pkg::op_t'(operation) == ttps_pkg::OP_PROBE ||
                                ttps_pkg::op_t'(operation) == ttps_pkg::OP_STORE);

  ttps_index #(.ENTRIES(ENTRIES)) u_index (
    .clk   (clk),
    .rst   (rst),
    .start (idx_start),
    .key   (key),
    .done  (idx_done),
    .idx   (idx)
  );

  ttps_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wr),
    .re    (idx_done),
    .raddr (idx),
    .rdata (ent_rdata)
  );

  ttps_ram #(.WIDTH(MOVE_BITS), .DEPTH(ENTRIES)) u_mv_ram (
    .clk   (clk),
    .we    (mv_we),
    .waddr (req_idx),
    .wdata (mv_wdata),
    .re    (idx_done),
    .raddr (idx),
    .rdata (mv_rdata)
  );

  assign ent_rd = ent_rdata;

  // Fit the 32-bit move port to the stored move width.
  if (MOVE_BITS > 32) begin : g_mv_wide
    assign mv_wdata = req_has_move ? {{(MOVE_BITS - 32){1'b0}}, req_move} : '0;
    assign mv_rd32  = mv_rdata[31:0];
  end else begin : g_mv_narrow
    assign mv_wdata = req_has_move ? req_move[MOVE_BITS-1:0] : '0;
    assign mv_rd32  = 32'(mv_rdata);
  end

  // Probe and replacement decision on the slot just read
  always_comb begin
    lk_score = signed'(ent_rd.score);
    lk_hit   = ent_rd.valid && (ent_rd.key == req_key);
    lk_deep  = (ent_rd.depth >= req_depth);
    lk_alpha = req_alpha;
    lk_beta  = req_beta;
    lk_cut   = 1'b0;
    if (lk_hit && lk_deep) begin
      unique case (ent_rd.bound)
        ttps_pkg::BOUND_EXACT: begin
          lk_cut = 1'b1;
        end
        ttps_pkg::BOUND_LOWER: begin
          if (lk_score > lk_alpha) begin
            lk_alpha = lk_score;
          end
          lk_cut = (lk_alpha >= lk_beta);
        end
        ttps_pkg::BOUND_UPPER: begin
          if (lk_score < lk_beta) begin
            lk_beta = lk_score;
          end
          lk_cut = (lk_alpha >= lk_beta);
        end
        default: begin
          lk_cut = (lk_alpha >= lk_beta);
        end
      endcase
    end
    lk_repl = (req_bound != 2'd3) &&
              (!ent_rd.valid || ent_rd.age != generation || req_depth >= ent_rd.depth);
  end

  // Memory write port: the clearing sweep or a replacing store
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = req_idx;
    ent_wr    = '0;
    mv_we     = 1'b0;
    if (state == ST_CLEAR) begin
      ent_we    = 1'b1;
      ent_waddr = sweep;
    end else if (state == ST_LOOKUP && req_op == ttps_pkg::OP_STORE && lk_repl) begin
      ent_we          = 1'b1;
      mv_we           = 1'b1;
      ent_wr.valid    = 1'b1;
      ent_wr.key      = req_key;
      ent_wr.score    = req_score;
      ent_wr.depth    = req_depth;
      ent_wr.bound    = req_bound;
      ent_wr.age      = generation;
      ent_wr.has_move = req_has_move;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (ttps_pkg::op_t'(operation))
            ttps_pkg::OP_PROBE, ttps_pkg::OP_STORE: begin
              state_next = idx_done ? ST_LOOKUP : ST_INDEX;
            end
            ttps_pkg::OP_NEWGEN: begin
              state_next = (generation == '1) ? ST_CLEAR : ST_IDLE;
            end
            ttps_pkg::OP_CLEAR: begin
              state_next = ST_CLEAR;
            end
          endcase
        end
      end
      ST_INDEX: begin
        if (idx_done) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        if (sweep == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      sweep      <= '0;
      generation <= 32'd1;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= accept ? (ttps_pkg::op_t'(operation) == ttps_pkg::OP_NEWGEN ||
                         ttps_pkg::op_t'(operation) == ttps_pkg::OP_CLEAR)
                      : (state == ST_LOOKUP);
      if (state == ST_CLEAR) begin
        sweep <= sweep + 1'b1;
      end else begin
        sweep <= '0;
      end
      if (accept && ttps_pkg::op_t'(operation) == ttps_pkg::OP_NEWGEN) begin
        // wrap skips zero
        generation <= (generation == '1) ? 32'd1 : generation + 32'd1;
      end
    end
  end

  // Hold the request for the lookup stage
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op       <= ttps_pkg::op_t'(operation);
      req_key      <= key;
      req_depth    <= depth;
      req_score    <= score;
      req_bound    <= bound;
      req_alpha    <= alpha;
      req_beta     <= beta;
      req_has_move <= has_move;
      req_move     <= move;
    end
    if (idx_done) begin
      req_idx <= idx;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      hit          <= 1'b0;
      cutoff       <= 1'b0;
      cutoff_score <= '0;
      new_alpha    <= '0;
      new_beta     <= '0;
      entry_depth  <= '0;
      entry_bound  <= '0;
      move_valid   <= 1'b0;
      move_out     <= '0;
      written      <= 1'b0;
    end else if (state == ST_LOOKUP) begin
      if (req_op == ttps_pkg::OP_PROBE) begin
        hit          <= lk_hit;
        cutoff       <= lk_cut;
        cutoff_score <= lk_cut ? lk_score : '0;
        new_alpha    <= lk_alpha;
        new_beta     <= lk_beta;
        entry_depth  <= lk_hit ? ent_rd.depth : '0;
        entry_bound  <= lk_hit ? ent_rd.bound : '0;
        move_valid   <= lk_hit && ent_rd.has_move;
        move_out     <= (lk_hit && ent_rd.has_move) ? mv_rd32 : '0;
        written      <= 1'b0;
      end else begin
        hit          <= 1'b0;
        cutoff       <= 1'b0;
        cutoff_score <= '0;
        new_alpha    <= '0;
        new_beta     <= '0;
        entry_depth  <= '0;
        entry_bound  <= '0;
        move_valid   <= 1'b0;
        move_out     <= '0;
        written      <= lk_repl;
      end
    end
  end

endmodule
`default_nettype wire
